// ===== rtl/spwm_pkg.sv =====
package spwm_pkg;

  // Field widths of the request and result channels.
  localparam int unsigned CH_W    = 4;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned ADDR_W  = 7;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned PHASE_W = 12;

  // Largest channel count that the channel field can address.
  localparam int unsigned MAX_CHANNELS     = 16;
  localparam int unsigned DEFAULT_CHANNELS = 16;

  // Register map and special duty codes.
  localparam logic [ADDR_W-1:0]  BASE_ADDR = 7'h06;
  localparam logic [COUNT_W-1:0] FULL_MARK = 13'd4096;
  localparam logic [DUTY_W-1:0]  DUTY_OFF  = 16'h0000;
  localparam logic [DUTY_W-1:0]  DUTY_FULL = 16'hFFFF;

  // Request kinds.
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

// ===== rtl/staggered_pwm_phase_update.sv =====
// Staggered PWM phase update. A store request (kind 0) writes one channel duty; a store
// to a channel at or beyond CHANNELS is dropped. A flush request (kind 1) first scans
// all CHANNELS entries, one per cycle, comparing each duty with the shadow of what was
// last sent, then walks from the first changed channel to the last changed one, one
// channel per cycle while the result side does not stall, producing one register write
// per channel through a single 12-bit phase adder. A flush with no changed channel
// gives no result. in_stall is high for the whole of a flush. The final result carries
// last = 1, and the next request may be taken while that result still waits in the
// output register.
module staggered_pwm_phase_update #(
  parameter int unsigned CHANNELS = spwm_pkg::DEFAULT_CHANNELS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         kind,
  input  logic [spwm_pkg::CH_W-1:0]    channel,
  input  logic [spwm_pkg::DUTY_W-1:0]  duty,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [spwm_pkg::ADDR_W-1:0]  reg_addr,
  output logic [spwm_pkg::COUNT_W-1:0] on_count,
  output logic [spwm_pkg::COUNT_W-1:0] off_count,
  output logic                         last
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);
  localparam logic [spwm_pkg::CH_W:0] CH_LIMIT = (spwm_pkg::CH_W + 1)'(CHANNELS);

  spwm_pkg::state_t state;

  logic [spwm_pkg::DUTY_W-1:0]  duty_store [CHANNELS];
  logic [spwm_pkg::DUTY_W-1:0]  sent_shadow [CHANNELS];
  logic [IDX_W-1:0]             idx;
  logic [IDX_W-1:0]             first_ch;
  logic [IDX_W-1:0]             last_ch;
  logic                         found;
  logic [spwm_pkg::PHASE_W-1:0] phase;

  logic                         in_take;
  logic                         store_ok;
  logic [spwm_pkg::DUTY_W-1:0]  cur_duty;
  logic                         changed;
  logic                         slot_free;
  logic                         emit_load;
  logic [spwm_pkg::PHASE_W-1:0] phase_sum;

  // Shared datapath: one read port on the stores at the walk index, one phase adder.
  always_comb begin
    in_take   = in_valid && !in_stall;
    store_ok  = ({1'b0, channel} < CH_LIMIT);
    cur_duty  = duty_store[idx];
    changed   = (cur_duty != sent_shadow[idx]);
    slot_free = !out_valid || !out_stall;
    emit_load = (state == spwm_pkg::ST_EMIT) && slot_free;
    phase_sum = phase + cur_duty[spwm_pkg::DUTY_W-1:4];
  end

  assign in_stall = (state != spwm_pkg::ST_IDLE);

  // Duty store and shadow. The shadow is refreshed for each channel as it is written out.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        duty_store[i]  <= '0;
        sent_shadow[i] <= '0;
      end
    end else begin
      if (in_take && kind == spwm_pkg::KIND_STORE && store_ok) begin
        duty_store[channel[IDX_W-1:0]] <= duty;
      end
      if (emit_load) begin
        sent_shadow[idx] <= cur_duty;
      end
    end
  end

  // Sequencer: idle, scan for the changed range, then emit one write per channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= spwm_pkg::ST_IDLE;
      idx      <= '0;
      first_ch <= '0;
      last_ch  <= '0;
      found    <= 1'b0;
      phase    <= '0;
    end else begin
      case (state)
        spwm_pkg::ST_IDLE: begin
          if (in_take && kind == spwm_pkg::KIND_FLUSH) begin
            state <= spwm_pkg::ST_SCAN;
            idx   <= '0;
            found <= 1'b0;
          end
        end
        spwm_pkg::ST_SCAN: begin
          if (changed) begin
            if (!found) begin
              first_ch <= idx;
            end
            found   <= 1'b1;
            last_ch <= idx;
          end
          if (idx == LAST_IDX) begin
            phase <= '0;
            if (found) begin
              state <= spwm_pkg::ST_EMIT;
              idx   <= first_ch;
            end else if (changed) begin
              state <= spwm_pkg::ST_EMIT;
            end else begin
              state <= spwm_pkg::ST_IDLE;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        spwm_pkg::ST_EMIT: begin
          if (emit_load) begin
            if (cur_duty != spwm_pkg::DUTY_OFF && cur_duty != spwm_pkg::DUTY_FULL) begin
              phase <= phase_sum;
            end
            if (idx == last_ch) begin
              state <= spwm_pkg::ST_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: begin
          state <= spwm_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Output register: valid flag under reset, payload loaded when the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      reg_addr <= spwm_pkg::BASE_ADDR + spwm_pkg::ADDR_W'({idx, 2'b00});
      last     <= (idx == last_ch);
      if (cur_duty == spwm_pkg::DUTY_OFF) begin
        on_count  <= '0;
        off_count <= spwm_pkg::FULL_MARK;
      end else if (cur_duty == spwm_pkg::DUTY_FULL) begin
        on_count  <= spwm_pkg::FULL_MARK;
        off_count <= '0;
      end else begin
        on_count  <= {1'b0, phase};
        off_count <= {1'b0, phase_sum};
      end
    end
  end

`ifndef SYNTHESIS
  // The walk never runs past the last changed channel.
  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == spwm_pkg::ST_EMIT) |-> (idx <= last_ch && first_ch <= last_ch))
    else $error("emit index beyond last changed channel");

  // Loading the last channel's write returns the sequencer to idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (emit_load && idx == last_ch) |=> (state == spwm_pkg::ST_IDLE && out_valid && last))
    else $error("final write did not end the flush");

  // While the result side stalls, the walk does not move on.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == spwm_pkg::ST_EMIT && out_valid && out_stall) |=> $stable(idx))
    else $error("walk advanced while the output was stalled");
`endif

endmodule
